[hdl/obdl_pkg.sv]
// package for the order book depth ladder
// types, codes and default sizes shared by the interfaces, the level cell and the top level
`default_nettype none

package obdl_pkg;

  localparam int unsigned DepthDefault     = 5;
  localparam int unsigned PriceBitsDefault = 32;

  localparam int unsigned KindW   = 3;
  localparam int unsigned PriceW  = 32;
  localparam int unsigned QtyW    = 16;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TouchW  = 3;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_APPLIED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  // operation as seen by every cell
  typedef struct packed {
    kind_e           kind;
    logic            side;
    logic [QtyW-1:0] qty;
  } cmd_t;

  // search state rippling from best level toward worst
  typedef struct packed {
    logic stopped;
    logic found;
  } chain_t;

endpackage

`default_nettype wire

[hdl/obdl_item_if.sv]
// valid/ready channel carrying one book operation
// payload widths come from obdl_pkg
`default_nettype none

interface obdl_item_if;
  logic                         valid;
  logic                         ready;
  logic [obdl_pkg::KindW-1:0]   kind;
  logic                         side;
  logic [obdl_pkg::PriceW-1:0]  price;
  logic [obdl_pkg::QtyW-1:0]    quantity;
  logic [obdl_pkg::LevelW-1:0]  level;

  modport source (output valid, kind, side, price, quantity, level, input ready);
  modport sink   (input valid, kind, side, price, quantity, level, output ready);
endinterface

`default_nettype wire

[hdl/obdl_result_if.sv]
// valid/ready channel carrying one operation result
// payload widths come from obdl_pkg
`default_nettype none

interface obdl_result_if;
  logic                          valid;
  logic                          ready;
  logic [obdl_pkg::StatusW-1:0]  status;
  logic [obdl_pkg::PriceW-1:0]   level_price;
  logic [obdl_pkg::QtyW-1:0]     level_quantity;
  logic [obdl_pkg::TouchW-1:0]   touched_level;
  logic                          best_ok;

  modport source (output valid, status, level_price, level_quantity, touched_level, best_ok,
                  input ready);
  modport sink   (input valid, status, level_price, level_quantity, touched_level, best_ok,
                  output ready);
endinterface

`default_nettype wire

[hdl/obdl_cell.sv]
// one price level of both ladders: local compare, search ripple and shift
// depends on obdl_pkg for cmd_t, chain_t and kind_e
`default_nettype none

module obdl_cell #(
  parameter int unsigned PriceBits = obdl_pkg::PriceBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire obdl_pkg::cmd_t              cmd_i,
  input  wire logic [PriceBits-1:0]        price_i,
  input  wire obdl_pkg::chain_t            chain_i,
  output      obdl_pkg::chain_t            chain_o,
  output      logic                        hit_o,
  input  wire logic [PriceBits-1:0]        prev_bid_p_i,
  input  wire logic [obdl_pkg::QtyW-1:0]   prev_bid_q_i,
  input  wire logic [PriceBits-1:0]        prev_ask_p_i,
  input  wire logic [obdl_pkg::QtyW-1:0]   prev_ask_q_i,
  input  wire logic [PriceBits-1:0]        next_bid_p_i,
  input  wire logic [obdl_pkg::QtyW-1:0]   next_bid_q_i,
  input  wire logic [PriceBits-1:0]        next_ask_p_i,
  input  wire logic [obdl_pkg::QtyW-1:0]   next_ask_q_i,
  output      logic [PriceBits-1:0]        bid_p_o,
  output      logic [obdl_pkg::QtyW-1:0]   bid_q_o,
  output      logic [PriceBits-1:0]        ask_p_o,
  output      logic [obdl_pkg::QtyW-1:0]   ask_q_o
);

  logic [PriceBits-1:0]      bid_p_q, bid_p_d, ask_p_q, ask_p_d;
  logic [obdl_pkg::QtyW-1:0] bid_q_q, bid_q_d, ask_q_q, ask_q_d;
  logic [PriceBits-1:0]      cur_p, sel_p_d;
  logic [obdl_pkg::QtyW-1:0] cur_q, sel_q_d;
  logic                      empty, eq, beyond, my_stop, found_here;

  assign cur_p = cmd_i.side ? ask_p_q : bid_p_q;
  assign cur_q = cmd_i.side ? ask_q_q : bid_q_q;

  // empty level means price and quantity both zero
  assign empty      = (cur_p == '0) && (cur_q == '0);
  assign eq         = (price_i == cur_p);
  assign beyond     = cmd_i.side ? (price_i < cur_p) : (price_i > cur_p);
  assign my_stop    = empty || eq || beyond;
  assign found_here = !empty && eq;

  assign hit_o           = !chain_i.stopped && my_stop;
  assign chain_o.stopped = chain_i.stopped || my_stop;
  assign chain_o.found   = chain_i.stopped ? chain_i.found : found_here;

  always_comb begin
    sel_p_d = cur_p;
    sel_q_d = cur_q;
    bid_p_d = bid_p_q;
    bid_q_d = bid_q_q;
    ask_p_d = ask_p_q;
    ask_q_d = ask_q_q;
    case (cmd_i.kind)
      obdl_pkg::KIND_INSERT: begin
        if (hit_o && !found_here) begin
          sel_p_d = price_i;
          sel_q_d = cmd_i.qty;
        end else if (chain_i.stopped && !chain_i.found) begin
          // shift down from the better neighbor
          sel_p_d = cmd_i.side ? prev_ask_p_i : prev_bid_p_i;
          sel_q_d = cmd_i.side ? prev_ask_q_i : prev_bid_q_i;
        end
      end
      obdl_pkg::KIND_UPDATE: begin
        if (hit_o && found_here) begin
          sel_q_d = cmd_i.qty;
        end
      end
      obdl_pkg::KIND_DELETE: begin
        if ((hit_o && found_here) || (chain_i.stopped && chain_i.found)) begin
          // shift up from the worse neighbor, last cell pulls in zero
          sel_p_d = cmd_i.side ? next_ask_p_i : next_bid_p_i;
          sel_q_d = cmd_i.side ? next_ask_q_i : next_bid_q_i;
        end
      end
      default: ;
    endcase
    if (cmd_i.side) begin
      ask_p_d = sel_p_d;
      ask_q_d = sel_q_d;
    end else begin
      bid_p_d = sel_p_d;
      bid_q_d = sel_q_d;
    end
    if (cmd_i.kind == obdl_pkg::KIND_CLEAR) begin
      bid_p_d = '0;
      bid_q_d = '0;
      ask_p_d = '0;
      ask_q_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_p_q <= '0;
      bid_q_q <= '0;
      ask_p_q <= '0;
      ask_q_q <= '0;
    end else if (en_i) begin
      bid_p_q <= bid_p_d;
      bid_q_q <= bid_q_d;
      ask_p_q <= ask_p_d;
      ask_q_q <= ask_q_d;
    end
  end

  assign bid_p_o = bid_p_q;
  assign bid_q_o = bid_q_q;
  assign ask_p_o = ask_p_q;
  assign ask_q_o = ask_q_q;

endmodule

`default_nettype wire

[hdl/order_book_depth_ladder.sv]
// order book depth ladder: each item is held in the command register, then executed into the result register
// throughput one item per cycle while results are taken; the execute cycle resolves the search ripple through
// all LadderDepth cells and shifts the ladders in that same cycle; a stalled result holds
// the item in the command register, and only then is the input stalled
// reset (async, active low) empties both ladders and drops any pending item and result
// depends on obdl_pkg, obdl_item_if, obdl_result_if and obdl_cell
`default_nettype none

module order_book_depth_ladder #(
  parameter int unsigned LadderDepth = obdl_pkg::DepthDefault,
  parameter int unsigned PriceBits   = obdl_pkg::PriceBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  obdl_item_if.sink      req,
  obdl_result_if.source  rsp
);

  localparam int unsigned PosW = $clog2(LadderDepth + 1);

  // command register, one item waiting to execute
  logic                           cmd_vld_q;
  obdl_pkg::cmd_t                 cmd_q;
  logic [PriceBits-1:0]           price_q;
  logic [obdl_pkg::LevelW-1:0]    level_q;

  // result register
  logic                           rsp_vld_q;
  obdl_pkg::status_e              status_q, status_d;
  logic [obdl_pkg::PriceW-1:0]    lvl_p_q, lvl_p_d;
  logic [obdl_pkg::QtyW-1:0]      lvl_q_q, lvl_q_d;
  logic [obdl_pkg::TouchW-1:0]    touch_q, touch_d;

  logic exec;
  logic req_xfer;

  // cell chain wiring; extra slot at each end feeds zero
  obdl_pkg::chain_t               chain_w [LadderDepth+1];
  logic [LadderDepth-1:0]         hit_w;
  logic [PriceBits-1:0]           bid_p_w [LadderDepth+2];
  logic [obdl_pkg::QtyW-1:0]      bid_q_w [LadderDepth+2];
  logic [PriceBits-1:0]           ask_p_w [LadderDepth+2];
  logic [obdl_pkg::QtyW-1:0]      ask_q_w [LadderDepth+2];

  logic [PosW-1:0]                pos;
  logic                           found;
  logic                           any_hit;
  logic                           lvl_ok;
  logic [PriceBits-1:0]           rd_p;
  logic [obdl_pkg::QtyW-1:0]      rd_q;

  // execute only when the result register is free or being emptied
  assign exec      = cmd_vld_q && (!rsp_vld_q || rsp.ready);
  assign req.ready = !cmd_vld_q || exec;
  assign req_xfer  = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_xfer) begin
        cmd_vld_q <= 1'b1;
      end else if (exec) begin
        cmd_vld_q <= 1'b0;
      end
      if (exec) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      cmd_q.kind <= obdl_pkg::kind_e'(req.kind);
      cmd_q.side <= req.side;
      cmd_q.qty  <= req.quantity;
      price_q    <= PriceBits'(req.price);
      level_q    <= req.level;
    end
    if (exec) begin
      status_q <= status_d;
      lvl_p_q  <= lvl_p_d;
      lvl_q_q  <= lvl_q_d;
      touch_q  <= touch_d;
    end
  end

  // level cells, best level first
  assign chain_w[0]           = '0;
  assign bid_p_w[0]           = '0;
  assign bid_q_w[0]           = '0;
  assign ask_p_w[0]           = '0;
  assign ask_q_w[0]           = '0;
  assign bid_p_w[LadderDepth+1] = '0;
  assign bid_q_w[LadderDepth+1] = '0;
  assign ask_p_w[LadderDepth+1] = '0;
  assign ask_q_w[LadderDepth+1] = '0;

  for (genvar g = 0; g < LadderDepth; g++) begin : g_cell
    obdl_cell #(
      .PriceBits(PriceBits)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (exec),
      .cmd_i       (cmd_q),
      .price_i     (price_q),
      .chain_i     (chain_w[g]),
      .chain_o     (chain_w[g+1]),
      .hit_o       (hit_w[g]),
      .prev_bid_p_i(bid_p_w[g]),
      .prev_bid_q_i(bid_q_w[g]),
      .prev_ask_p_i(ask_p_w[g]),
      .prev_ask_q_i(ask_q_w[g]),
      .next_bid_p_i(bid_p_w[g+2]),
      .next_bid_q_i(bid_q_w[g+2]),
      .next_ask_p_i(ask_p_w[g+2]),
      .next_ask_q_i(ask_q_w[g+2]),
      .bid_p_o     (bid_p_w[g+1]),
      .bid_q_o     (bid_q_w[g+1]),
      .ask_p_o     (ask_p_w[g+1]),
      .ask_q_o     (ask_q_w[g+1])
    );
  end

  assign found   = chain_w[LadderDepth].found;
  assign any_hit = chain_w[LadderDepth].stopped;

  // stop position from the one-hot hit vector, past end when no cell stopped
  always_comb begin
    pos = any_hit ? '0 : PosW'(LadderDepth);
    for (int i = 0; i < LadderDepth; i++) begin
      pos = pos | (hit_w[i] ? PosW'(i) : '0);
    end
  end

  // read level mux on the selected side
  assign lvl_ok = int'(level_q) < int'(LadderDepth);
  always_comb begin
    rd_p = '0;
    rd_q = '0;
    for (int i = 0; i < LadderDepth; i++) begin
      if (int'(level_q) == i) begin
        rd_p = cmd_q.side ? ask_p_w[i+1] : bid_p_w[i+1];
        rd_q = cmd_q.side ? ask_q_w[i+1] : bid_q_w[i+1];
      end
    end
  end

  always_comb begin
    status_d = obdl_pkg::ST_APPLIED;
    lvl_p_d  = '0;
    lvl_q_d  = '0;
    touch_d  = '0;
    case (cmd_q.kind)
      obdl_pkg::KIND_INSERT: begin
        touch_d = obdl_pkg::TouchW'(pos);
        if (found) begin
          status_d = obdl_pkg::ST_IGNORED;
        end else if (!any_hit) begin
          status_d = obdl_pkg::ST_DROPPED;
        end
      end
      obdl_pkg::KIND_UPDATE, obdl_pkg::KIND_DELETE: begin
        touch_d = obdl_pkg::TouchW'(pos);
        if (!found) begin
          status_d = obdl_pkg::ST_IGNORED;
        end
      end
      obdl_pkg::KIND_CLEAR: ;
      obdl_pkg::KIND_READ: begin
        if (lvl_ok) begin
          touch_d = level_q;
          lvl_p_d = obdl_pkg::PriceW'(rd_p);
          lvl_q_d = rd_q;
        end else begin
          touch_d  = obdl_pkg::TouchW'(LadderDepth);
          status_d = obdl_pkg::ST_DROPPED;
        end
      end
      default: status_d = obdl_pkg::ST_IGNORED;
    endcase
  end

  assign rsp.valid          = rsp_vld_q;
  assign rsp.status         = status_q;
  assign rsp.level_price    = lvl_p_q;
  assign rsp.level_quantity = lvl_q_q;
  assign rsp.touched_level  = touch_q;
  // ladders only change together with the result register, so the top of book
  // seen now is the state left by the item being reported
  assign rsp.best_ok = ((ask_p_w[1] == '0) && (ask_q_w[1] == '0)) || (bid_p_w[1] < ask_p_w[1]);

  // at most one cell can be the stop position
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_w))
    else $error("more than one level claims the search stop");

  // a found price always has a stop position
  a_found_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> any_hit)
    else $error("price found without a stop level");

  // after a clear the ask side is empty so the book cannot be crossed
  a_clear_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (cmd_q.kind == obdl_pkg::KIND_CLEAR)) |=> rsp.best_ok)
    else $error("book reported crossed right after clear");

  // execution never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && !rsp.ready) |-> !exec)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking bench for order_book_depth_ladder, driven over obdl_item_if and obdl_result_if
// a local model of both ladders predicts every result, which is compared field by field
// depends on obdl_pkg, obdl_item_if, obdl_result_if and the hdl top level
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth       = obdl_pkg::DepthDefault;
  localparam int RandomItems = 1950;
  localparam int PoolSize    = 8;
  localparam int HoldAt      = 600;   // result count at which the long receiver hold-off starts
  localparam int HoldCycles  = 120;
  localparam int StallLimit  = 1000;  // cycles with no transfer on either side
  localparam int TailCycles  = 8;

  localparam logic SideBid = 1'b0;
  localparam logic SideAsk = 1'b1;

  // kinds the block does not define, still legal on the 3-bit field
  localparam logic [obdl_pkg::KindW-1:0] KindSpareLo = 3'd5;
  localparam logic [obdl_pkg::KindW-1:0] KindSpareHi = 3'd7;

  typedef struct packed {
    logic [obdl_pkg::KindW-1:0]  kind;
    logic                        side;
    logic [obdl_pkg::PriceW-1:0] price;
    logic [obdl_pkg::QtyW-1:0]   quantity;
    logic [obdl_pkg::LevelW-1:0] level;
  } book_op_t;

  typedef struct packed {
    obdl_pkg::status_e           status;
    logic [obdl_pkg::PriceW-1:0] level_price;
    logic [obdl_pkg::QtyW-1:0]   level_quantity;
    logic [obdl_pkg::TouchW-1:0] touched_level;
    logic                        best_ok;
  } book_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  obdl_item_if   item_bus ();
  obdl_result_if result_bus ();

  order_book_depth_ladder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (item_bus),
    .rsp    (result_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of both ladders, index 0 is bid and 1 is ask
  logic [obdl_pkg::PriceW-1:0] ladder_px  [2][Depth];
  logic [obdl_pkg::QtyW-1:0]   ladder_qty [2][Depth];

  book_op_t     op_pending_q [$];   // items not yet offered
  book_result_t book_expect_q [$];  // predicted results in transfer order

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // ---------------------------------------------------------------------------
  // ladder model
  // ---------------------------------------------------------------------------

  function automatic bit level_is_empty(input logic side, input int idx);
    return ladder_px[side][idx] == '0 && ladder_qty[side][idx] == '0;
  endfunction

  // walk from best level; stops on a match, on the first worse price or on an empty level
  function automatic bit find_level(input logic side, input logic [obdl_pkg::PriceW-1:0] px,
                                    output int pos);
    bit hit;
    bit stop;
    hit  = 1'b0;
    stop = 1'b0;
    pos  = Depth;
    for (int i = 0; i < Depth && !stop; i++) begin
      if (level_is_empty(side, i)) begin
        pos  = i;
        stop = 1'b1;
      end else if (px == ladder_px[side][i]) begin
        pos  = i;
        hit  = 1'b1;
        stop = 1'b1;
      end else if (side == SideAsk ? (px < ladder_px[side][i]) : (px > ladder_px[side][i])) begin
        pos  = i;
        stop = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic apply_book_op(input book_op_t op, output book_result_t res);
    int pos;
    bit hit;
    logic s;
    s   = op.side;
    res = '0;
    pos = 0;
    case (op.kind)
      obdl_pkg::KIND_INSERT: begin
        hit = find_level(s, op.price, pos);
        res.touched_level = obdl_pkg::TouchW'(pos);
        if (hit) begin
          res.status = obdl_pkg::ST_IGNORED;
        end else if (pos >= Depth) begin
          res.status = obdl_pkg::ST_DROPPED;
        end else begin
          // worst level falls off the end
          for (int i = Depth - 1; i > pos; i--) begin
            ladder_px[s][i]  = ladder_px[s][i-1];
            ladder_qty[s][i] = ladder_qty[s][i-1];
          end
          ladder_px[s][pos]  = op.price;
          ladder_qty[s][pos] = op.quantity;
        end
      end
      obdl_pkg::KIND_UPDATE: begin
        hit = find_level(s, op.price, pos);
        res.touched_level = obdl_pkg::TouchW'(pos);
        if (hit) ladder_qty[s][pos] = op.quantity;
        else     res.status = obdl_pkg::ST_IGNORED;
      end
      obdl_pkg::KIND_DELETE: begin
        hit = find_level(s, op.price, pos);
        res.touched_level = obdl_pkg::TouchW'(pos);
        if (hit) begin
          for (int i = pos; i + 1 < Depth; i++) begin
            ladder_px[s][i]  = ladder_px[s][i+1];
            ladder_qty[s][i] = ladder_qty[s][i+1];
          end
          ladder_px[s][Depth-1]  = '0;
          ladder_qty[s][Depth-1] = '0;
        end else begin
          res.status = obdl_pkg::ST_IGNORED;
        end
      end
      obdl_pkg::KIND_CLEAR: begin
        for (int i = 0; i < Depth; i++) begin
          ladder_px[SideBid][i]  = '0;
          ladder_qty[SideBid][i] = '0;
          ladder_px[SideAsk][i]  = '0;
          ladder_qty[SideAsk][i] = '0;
        end
      end
      obdl_pkg::KIND_READ: begin
        if (op.level < Depth) begin
          res.touched_level  = obdl_pkg::TouchW'(op.level);
          res.level_price    = ladder_px[s][op.level];
          res.level_quantity = ladder_qty[s][op.level];
        end else begin
          res.touched_level = obdl_pkg::TouchW'(Depth);
          res.status        = obdl_pkg::ST_DROPPED;
        end
      end
      default: begin
        res.status = obdl_pkg::ST_IGNORED;
      end
    endcase
    // crossed-book check on the ladders after the operation
    res.best_ok = level_is_empty(SideAsk, 0) || (ladder_px[SideBid][0] < ladder_px[SideAsk][0]);
  endtask

  function automatic book_op_t make_op(input logic [obdl_pkg::KindW-1:0] kind,
                                       input logic side,
                                       input logic [obdl_pkg::PriceW-1:0] price,
                                       input logic [obdl_pkg::QtyW-1:0] quantity,
                                       input logic [obdl_pkg::LevelW-1:0] level);
    book_op_t op;
    op.kind     = kind;
    op.side     = side;
    op.price    = price;
    op.quantity = quantity;
    op.level    = level;
    return op;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // item driver: offers queued items, each after a random gap
  // ---------------------------------------------------------------------------

  book_op_t     op_on_bus;
  book_result_t op_prediction;
  int           send_gap = 0;
  int           ops_sent = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        // transfer taken: advance the model and queue what the block must answer
        apply_book_op(op_on_bus, op_prediction);
        book_expect_q.push_back(op_prediction);
        ops_sent++;
        // every third window of 150 items runs back to back
        send_gap = (((ops_sent / 150) % 3) == 0) ? 0 : $urandom_range(0, 7);
      end
      if (item_bus.valid && !item_bus.ready) begin
        // hold the offered item until the block takes it
      end else if (send_gap > 0) begin
        send_gap--;
        item_bus.valid <= 1'b0;
      end else if (op_pending_q.size() > 0) begin
        op_on_bus = op_pending_q.pop_front();
        item_bus.valid    <= 1'b1;
        item_bus.kind     <= op_on_bus.kind;
        item_bus.side     <= op_on_bus.side;
        item_bus.price    <= op_on_bus.price;
        item_bus.quantity <= op_on_bus.quantity;
        item_bus.level    <= op_on_bus.level;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random stalls, one long hold-off, in-order compare
  // ---------------------------------------------------------------------------

  book_result_t result_wanted;
  int           take_stall   = 0;
  int           hold_left    = 0;
  int           results_seen = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      take_stall = 0;
      hold_left  = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (book_expect_q.size() == 0) begin
          $display("%0t: result with none expected, status %0d touched %0d", $time,
                   result_bus.status, result_bus.touched_level);
          mismatch_count++;
        end else begin
          result_wanted = book_expect_q.pop_front();
          check_field("status", 64'(result_wanted.status), 64'(result_bus.status));
          check_field("level_price", 64'(result_wanted.level_price),
                      64'(result_bus.level_price));
          check_field("level_quantity", 64'(result_wanted.level_quantity),
                      64'(result_bus.level_quantity));
          check_field("touched_level", 64'(result_wanted.touched_level),
                      64'(result_bus.touched_level));
          check_field("best_ok", 64'(result_wanted.best_ok), 64'(result_bus.best_ok));
        end
        results_seen++;
        take_stall = (((results_seen / 170) % 3) == 2) ? 0 : $urandom_range(0, 7);
        // long hold-off so the pipeline backs up into the input side
        if (results_seen == HoldAt) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (take_stall > 0) begin
        take_stall--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: run of cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  logic [obdl_pkg::PriceW-1:0] price_pool [PoolSize];

  initial begin
    int   counted;
    int   roll;
    int   n;
    bit   timed_out;
    logic [obdl_pkg::PriceW-1:0] px;
    logic [obdl_pkg::QtyW-1:0]   qty;

    rst_ni            = 1'b0;
    item_bus.valid    = 1'b0;
    item_bus.kind     = obdl_pkg::KIND_READ;
    item_bus.side     = SideBid;
    item_bus.price    = '0;
    item_bus.quantity = '0;
    item_bus.level    = '0;
    result_bus.ready  = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      ladder_px[SideBid][i]  = '0;
      ladder_qty[SideBid][i] = '0;
      ladder_px[SideAsk][i]  = '0;
      ladder_qty[SideAsk][i] = '0;
    end

    // directed: empty book, out-of-range reads, misses on empty ladders
    op_pending_q.push_back(make_op(obdl_pkg::KIND_READ,   SideBid, '0, '0, 3'd0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_READ,   SideAsk, '0, '0, 3'd7));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_READ,   SideBid, '0, '0, 3'd5));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_UPDATE, SideBid, 32'd100, 16'd9, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_DELETE, SideAsk, 32'd100, '0, '0));
    // fill the bid ladder out of order, top price and quantity first
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, '1, '1, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd100, 16'd1, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd300, 16'd3, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd200, 16'd2, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd50, 16'd5, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd10, 16'd7, '0));
    // full ladder: worse price dropped, duplicate ignored, mid insert pushes last off
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd5, 16'd4, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd200, 16'd8, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideBid, 32'd250, 16'd6, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_UPDATE, SideBid, 32'd200, 16'd0, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_DELETE, SideBid, '1, '0, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_DELETE, SideBid, 32'd7, '0, '0));
    // ask below best bid gives a crossed book
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideAsk, 32'd150, 16'd2, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideAsk, '1, '0, '0));
    // zero price with zero quantity reads back as an empty best ask
    op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, SideAsk, '0, '0, '0));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_READ,   SideAsk, '0, '0, 3'd4));
    op_pending_q.push_back(make_op(KindSpareLo, SideAsk, 32'd150, 16'd3, 3'd2));
    op_pending_q.push_back(make_op(KindSpareHi, SideBid, '1, '1, 3'd7));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_CLEAR,  SideBid, 32'd300, 16'd1, 3'd1));
    op_pending_q.push_back(make_op(obdl_pkg::KIND_READ,   SideBid, '0, '0, 3'd0));

    // random: prices mostly from a small pool so levels are hit, ladders fill and drop
    counted = 0;
    n       = 0;
    while (counted < RandomItems) begin
      if (n % 100 == 0) begin
        for (int k = 0; k < PoolSize; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 55)      price_pool[k] = $urandom;
          else if (roll < 92) price_pool[k] = $urandom_range(1, 40);
          else if (roll < 96) price_pool[k] = '0;
          else                price_pool[k] = '1;
        end
      end
      n++;
      px  = ($urandom_range(0, 9) == 0) ? obdl_pkg::PriceW'($urandom)
                                        : price_pool[$urandom_range(0, PoolSize - 1)];
      qty = ($urandom_range(0, 9) == 0) ? '0 : obdl_pkg::QtyW'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        op_pending_q.push_back(make_op(obdl_pkg::KIND_INSERT, 1'($urandom), px, qty,
                                       3'($urandom)));
      end else if (roll < 55) begin
        op_pending_q.push_back(make_op(obdl_pkg::KIND_UPDATE, 1'($urandom), px, qty,
                                       3'($urandom)));
      end else if (roll < 75) begin
        op_pending_q.push_back(make_op(obdl_pkg::KIND_DELETE, 1'($urandom), px, qty,
                                       3'($urandom)));
      end else if (roll < 78) begin
        op_pending_q.push_back(make_op(obdl_pkg::KIND_CLEAR, 1'($urandom), px, qty,
                                       3'($urandom)));
      end else if (roll < 96) begin
        op_pending_q.push_back(make_op(obdl_pkg::KIND_READ, 1'($urandom), px, qty,
                                       3'($urandom_range(0, 7))));
      end else begin
        // spare kinds do nothing and are not counted
        op_pending_q.push_back(make_op(
            obdl_pkg::KindW'($urandom_range(KindSpareLo, KindSpareHi)),
            1'($urandom), px, qty, 3'($urandom)));
        counted--;
      end
      counted++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last item to go in and its result to come out
    @(negedge clk_i);
    while (!(op_pending_q.size() == 0 && !item_bus.valid && book_expect_q.size() == 0) &&
           quiet_cycles < StallLimit) begin
      @(negedge clk_i);
    end
    timed_out = quiet_cycles >= StallLimit;
    if (!timed_out) repeat (TailCycles) @(negedge clk_i);

    if (!timed_out && mismatch_count == 0 && book_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[order_book_depth_ladder.f]
hdl/obdl_pkg.sv
hdl/obdl_item_if.sv
hdl/obdl_result_if.sv
hdl/obdl_cell.sv
hdl/order_book_depth_ladder.sv
verif/testbench.sv
